// ===== hdl/u2u16_pkg.sv =====
// Shared types, codes and tables of the byte-stream to UTF-16 converter.
`timescale 1ns / 1ps

package u2u16_pkg;

    // Result status codes
    localparam logic [1:0] STATUS_OK       = 2'd0;
    localparam logic [1:0] STATUS_ABORT    = 2'd1;
    localparam logic [1:0] STATUS_CAPACITY = 2'd2;

    // Configuration register indexes
    localparam logic [1:0] CFG_SOURCE_IS_UTF8  = 2'd0;
    localparam logic [1:0] CFG_STOP_ON_INVALID = 2'd1;
    localparam logic [1:0] CFG_STOP_AT_NUL     = 2'd2;
    localparam logic [1:0] CFG_OUT_CAPACITY    = 2'd3;

    // Code point constants
    localparam logic [20:0] CP_REPLACEMENT = 21'h00FFFD;
    localparam logic [20:0] CP_MAX         = 21'h10FFFF;
    localparam logic [20:0] CP_BMP_MAX     = 21'h00FFFF;
    localparam logic [20:0] CP_PLANE1      = 21'h010000;
    localparam logic [15:0] HI_SURROGATE   = 16'hD800;
    localparam logic [15:0] LO_SURROGATE   = 16'hDC00;

    // Result queue depth
    localparam int RES_DEPTH = 4;
    localparam int RES_PTR_W = $clog2(RES_DEPTH);

    // Windows-1252 code points for bytes 0x80..0x9F
    localparam logic [15:0] CP1252_HI [0:31] = '{
        16'h20AC, 16'h0081, 16'h201A, 16'h0192, 16'h201E, 16'h2026, 16'h2020, 16'h2021,
        16'h02C6, 16'h2030, 16'h0160, 16'h2039, 16'h0152, 16'h008D, 16'h017D, 16'h008F,
        16'h0090, 16'h2018, 16'h2019, 16'h201C, 16'h201D, 16'h2022, 16'h2013, 16'h2014,
        16'h02DC, 16'h2122, 16'h0161, 16'h203A, 16'h0153, 16'h009D, 16'h017E, 16'h0178
    };

    typedef struct packed {
        logic [15:0] code_unit;
        logic [1:0]  status;
        logic        saw_invalid;
        logic        is_last;
        logic [15:0] unit_count;
    } u2u16_result_t;

    typedef struct packed {
        logic [20:0] partial;
        logic [1:0]  need;
        logic [15:0] produced;
        logic        draining;
    } u2u16_state_t;

    typedef struct packed {
        logic        source_is_utf8;
        logic        stop_on_invalid;
        logic        stop_at_nul;
        logic [15:0] out_capacity;
    } u2u16_cfg_t;

endpackage

// ===== hdl/utf8_or_cp1252_to_utf16_unit.sv =====
// Top level of the UTF-8 / Windows-1252 to UTF-16 converter.
//
//   Channel   Ports         Carries
//   s_        valid/ready   one source byte and its last-byte mark per request
//   m_        valid/ready   one UTF-16 code unit with status and count per request
//   cfg_      write only    register index and data, taken on cfg_wr_en
//
// One byte is taken per cycle while the result queue has room; a byte that
// yields a surrogate pair or a replacement plus a unit gives two results, and
// a byte inside an open sequence gives none. A request passes the input
// register, then the four-entry result queue, before its first result is shown.
// Decode stalls while the queue has fewer than two free entries.
// Reset is synchronous and active low and restores the register defaults.
`timescale 1ns / 1ps

module utf8_or_cp1252_to_utf16_unit (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_wr_en,
    input  logic [1:0]  cfg_index,
    input  logic [15:0] cfg_wr_data,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [7:0]  s_in_byte,
    input  logic        s_in_last,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [15:0] m_code_unit,
    output logic [1:0]  m_status,
    output logic        m_saw_invalid,
    output logic        m_is_last,
    output logic [15:0] m_unit_count
);
    import u2u16_pkg::*;

    u2u16_cfg_t          cfg_reg;
    u2u16_state_t        state_reg, state_next;
    logic                in_vld_reg;
    logic [7:0]          in_byte_reg;
    logic                in_last_reg;
    logic                fire;
    logic                room;
    logic [1:0]          dec_cnt;
    u2u16_result_t [1:0] dec_res;
    u2u16_result_t       head;
    logic                pop;

    // Configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.source_is_utf8  <= 1'b1;
            cfg_reg.stop_on_invalid <= 1'b0;
            cfg_reg.stop_at_nul     <= 1'b0;
            cfg_reg.out_capacity    <= 16'd0;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                CFG_SOURCE_IS_UTF8:  cfg_reg.source_is_utf8  <= cfg_wr_data[0];
                CFG_STOP_ON_INVALID: cfg_reg.stop_on_invalid <= cfg_wr_data[0];
                CFG_STOP_AT_NUL:     cfg_reg.stop_at_nul     <= cfg_wr_data[0];
                CFG_OUT_CAPACITY:    cfg_reg.out_capacity    <= cfg_wr_data;
                default: ;
            endcase
        end
    end

    // Input register: take a new request whenever the held one moves on
    assign fire    = in_vld_reg && room;
    assign s_ready = !in_vld_reg || fire;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_vld_reg <= 1'b0;
        end else if (s_ready) begin
            in_vld_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_byte_reg <= s_in_byte;
            in_last_reg <= s_in_last;
        end
    end

    // Stream state advances once per decoded byte
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= '0;
        end else if (fire) begin
            state_reg <= state_next;
        end
    end

    u2u16_decode u_decode (
        .cfg        (cfg_reg),
        .state      (state_reg),
        .in_byte    (in_byte_reg),
        .in_last    (in_last_reg),
        .res_cnt    (dec_cnt),
        .res        (dec_res),
        .state_next (state_next)
    );

    // Mark the final result of a stream that ends on this byte
    u2u16_result_t [1:0] push_res;
    logic                ends_here;

    assign ends_here = in_last_reg || state_next.draining;

    always_comb begin
        push_res = dec_res;
        if (ends_here && !state_reg.draining && dec_cnt != 2'd0) begin
            push_res[dec_cnt[1]].is_last = 1'b1;
        end
    end

    assign pop = m_valid && m_ready;

    u2u16_res_fifo u_res_fifo (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push_cnt   (fire ? dec_cnt : 2'd0),
        .push_data  (push_res),
        .pop        (pop),
        .room       (room),
        .head_valid (m_valid),
        .head       (head)
    );

    assign m_code_unit   = head.code_unit;
    assign m_status      = head.status;
    assign m_saw_invalid = head.saw_invalid;
    assign m_is_last     = head.is_last;
    assign m_unit_count  = head.unit_count;

    // A byte seen while draining produces nothing
    assert property (@(posedge aclk) disable iff (!aresetn)
        fire && state_reg.draining |-> dec_cnt == 2'd0)
        else $error("results produced while draining");

    // Error results always close the stream
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_status != STATUS_OK |-> m_is_last)
        else $error("error result not marked last");

    // Capacity errors carry no unit and no invalid flag
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_status == STATUS_CAPACITY |-> m_code_unit == 16'd0 && !m_saw_invalid)
        else $error("malformed capacity error result");

    // Stream state is clear after the last byte
    assert property (@(posedge aclk) disable iff (!aresetn)
        fire && in_last_reg |=> state_reg == '0)
        else $error("stream state not cleared at end");

endmodule

// ===== hdl/u2u16_decode.sv =====
// Decode of one source byte into up to two UTF-16 results and the next stream state.
`timescale 1ns / 1ps

module u2u16_decode (
    input  u2u16_pkg::u2u16_cfg_t          cfg,
    input  u2u16_pkg::u2u16_state_t        state,
    input  logic [7:0]                     in_byte,
    input  logic                           in_last,
    output logic [1:0]                     res_cnt,
    output u2u16_pkg::u2u16_result_t [1:0] res,
    output u2u16_pkg::u2u16_state_t        state_next
);
    import u2u16_pkg::*;

    // One code point request: a plain emit, a malformed mark, or a terminator
    typedef struct packed {
        logic        vld;
        logic        malf;
        logic        term;
        logic [20:0] cp;
    } req_t;

    typedef struct packed {
        req_t        req;
        logic [20:0] pcp;
        logic [1:0]  need;
    } lead_t;

    // Decode a byte found at a character boundary
    function automatic lead_t lead_decode(input logic [7:0] b, input logic nul_en,
                                          input logic [20:0] pcp_in);
        lead_t l;
        l      = '0;
        l.pcp  = pcp_in;
        priority if (nul_en && b == 8'h00) begin
            l.req.vld  = 1'b1;
            l.req.term = 1'b1;
        end else if (b < 8'h80) begin
            l.req.vld = 1'b1;
            l.req.cp  = {13'd0, b};
        end else if (b < 8'hC0) begin
            l.req.vld  = 1'b1;
            l.req.malf = 1'b1;
        end else if (b < 8'hE0) begin
            l.pcp  = {16'd0, b[4:0]};
            l.need = 2'd1;
        end else if (b < 8'hF0) begin
            l.pcp  = {17'd0, b[3:0]};
            l.need = 2'd2;
        end else if (b < 8'hF8) begin
            l.pcp  = {18'd0, b[2:0]};
            l.need = 2'd3;
        end else begin
            l.req.vld  = 1'b1;
            l.req.malf = 1'b1;
        end
        return l;
    endfunction

    function automatic u2u16_result_t mk_result(input logic [15:0] unit, input logic [1:0] st,
                                                input logic inv, input logic [15:0] cnt);
        u2u16_result_t r;
        r.code_unit   = unit;
        r.status      = st;
        r.saw_invalid = inv;
        r.is_last     = 1'b0;
        r.unit_count  = cnt;
        return r;
    endfunction

    function automatic logic [15:0] sat_inc(input logic [15:0] v);
        return (v == 16'hFFFF) ? v : v + 16'd1;
    endfunction

    req_t [2:0]  req;
    lead_t       lead;
    logic [20:0] pcp_n;
    logic [1:0]  need_n;
    logic [20:0] cp1252_cp;

    // Build the code point requests for this byte
    always_comb begin
        req       = '0;
        pcp_n     = state.partial;
        need_n    = state.need;
        cp1252_cp = (in_byte[7:5] == 3'b100) ? {5'd0, CP1252_HI[in_byte[4:0]]}
                                             : {13'd0, in_byte};
        lead      = lead_decode(in_byte, cfg.stop_at_nul, state.partial);
        if (!cfg.source_is_utf8) begin
            need_n     = 2'd0;
            req[0].vld = 1'b1;
            req[0].cp  = cp1252_cp;
            req[0].term = cfg.stop_at_nul && (in_byte == 8'h00);
        end else if (state.need != 2'd0) begin
            if (in_byte[7:6] == 2'b10) begin
                pcp_n  = {state.partial[14:0], in_byte[5:0]};
                need_n = state.need - 2'd1;
                if (need_n == 2'd0) begin
                    req[0].vld = 1'b1;
                    req[0].cp  = pcp_n;
                end
            end else begin
                // Bad continuation: replace, then decode the byte as a new lead
                req[0].vld  = 1'b1;
                req[0].malf = 1'b1;
                req[1]      = lead.req;
                pcp_n       = lead.pcp;
                need_n      = lead.need;
            end
        end else begin
            req[0] = lead.req;
            pcp_n  = lead.pcp;
            need_n = lead.need;
        end
        // Sequence still open at the end of the stream
        if (in_last && need_n != 2'd0) begin
            req[2].vld  = 1'b1;
            req[2].malf = 1'b1;
        end
    end

    logic        ended;
    logic [15:0] produced;
    logic [1:0]  n;
    logic [20:0] cp;
    logic [19:0] v;
    logic [1:0]  units;
    logic [16:0] sum;
    logic        inv;

    // Turn requests into results, checking capacity and early end
    always_comb begin
        ended    = 1'b0;
        produced = state.produced;
        n        = 2'd0;
        res      = '0;
        cp       = '0;
        v        = '0;
        units    = 2'd1;
        sum      = '0;
        inv      = 1'b0;
        for (int i = 0; i < 3; i++) begin
            if (req[i].vld && !ended) begin
                if (req[i].malf && cfg.stop_on_invalid) begin
                    res[n[0]] = mk_result(16'd0, STATUS_ABORT, 1'b1, produced);
                    n         = n + 2'd1;
                    ended     = 1'b1;
                end else begin
                    cp  = req[i].malf ? CP_REPLACEMENT : req[i].cp;
                    inv = req[i].malf;
                    if (cp > CP_MAX) begin
                        cp = CP_REPLACEMENT;
                    end
                    units = (cp > CP_BMP_MAX) ? 2'd2 : 2'd1;
                    sum   = {1'b0, produced} + {15'd0, units};
                    if (cfg.out_capacity != 16'd0 && sum > {1'b0, cfg.out_capacity}) begin
                        res[n[0]] = mk_result(16'd0, STATUS_CAPACITY, 1'b0, produced);
                        n         = n + 2'd1;
                        ended     = 1'b1;
                    end else if (units == 2'd1) begin
                        produced  = sat_inc(produced);
                        res[n[0]] = mk_result(cp[15:0], STATUS_OK, inv, produced);
                        n         = n + 2'd1;
                    end else begin
                        v         = cp[19:0] - CP_PLANE1[19:0];
                        produced  = sat_inc(produced);
                        res[n[0]] = mk_result(HI_SURROGATE | {6'd0, v[19:10]}, STATUS_OK,
                                              inv, produced);
                        n         = n + 2'd1;
                        produced  = sat_inc(produced);
                        res[n[0]] = mk_result(LO_SURROGATE | {6'd0, v[9:0]}, STATUS_OK,
                                              inv, produced);
                        n         = n + 2'd1;
                    end
                    if (req[i].term) begin
                        ended = 1'b1;
                    end
                end
            end
        end
    end

    // Mark the stream end and advance the state
    always_comb begin
        res_cnt    = n;
        state_next = state;
        if (state.draining) begin
            res_cnt = 2'd0;
            if (in_last) begin
                state_next = '0;
            end
        end else if (ended || in_last) begin
            if (n != 2'd0) begin
                res_cnt = n;
            end
            state_next          = '0;
            state_next.draining = !in_last;
        end else begin
            state_next.partial  = pcp_n;
            state_next.need     = need_n;
            state_next.produced = produced;
        end
    end

endmodule

// ===== hdl/u2u16_res_fifo.sv =====
// Small result queue that takes up to two results a cycle and hands out one.
`timescale 1ns / 1ps

module u2u16_res_fifo (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic [1:0]                     push_cnt,
    input  u2u16_pkg::u2u16_result_t [1:0] push_data,
    input  logic                           pop,
    output logic                           room,
    output logic                           head_valid,
    output u2u16_pkg::u2u16_result_t       head
);
    import u2u16_pkg::*;

    u2u16_result_t          mem_reg [RES_DEPTH];
    logic [RES_PTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [RES_PTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [RES_PTR_W:0]     count_reg, count_next;
    logic [RES_PTR_W-1:0]   wr_ptr_plus1;

    assign wr_ptr_plus1 = wr_ptr_reg + RES_PTR_W'(1);
    assign room         = count_reg <= (RES_PTR_W + 1)'(RES_DEPTH - 2);
    assign head_valid   = count_reg != '0;
    assign head         = mem_reg[rd_ptr_reg];

    // Advance pointers and the fill count
    always_comb begin
        wr_ptr_next = wr_ptr_reg + RES_PTR_W'(push_cnt);
        rd_ptr_next = rd_ptr_reg + RES_PTR_W'(pop);
        count_next  = count_reg + (RES_PTR_W + 1)'(push_cnt) - (RES_PTR_W + 1)'(pop);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Store incoming results
    always_ff @(posedge aclk) begin
        if (push_cnt != 2'd0) begin
            mem_reg[wr_ptr_reg] <= push_data[0];
        end
        if (push_cnt == 2'd2) begin
            mem_reg[wr_ptr_plus1] <= push_data[1];
        end
    end

endmodule

// ===== tb/sv/tb_utf8_or_cp1252_to_utf16_unit.sv =====
// Self-checking testbench for the UTF-8 / Windows-1252 to UTF-16 converter.
`timescale 1ns / 1ps

module tb_utf8_or_cp1252_to_utf16_unit;
    import u2u16_pkg::*;

    localparam int WATCHDOG_LIMIT = 2000;
    localparam int DRAIN_CYCLES   = 8;
    localparam int PHASE_COUNT    = 10;
    localparam int PHASE_BYTES    = 48;

    localparam logic [15:0] REPLACEMENT_UNIT = 16'hFFFD;
    localparam logic [20:0] LAST_CODE_POINT  = 21'h10FFFF;
    localparam logic [20:0] SUPPLEMENTARY    = 21'h010000;
    localparam logic [15:0] HIGH_HALF        = 16'hD800;
    localparam logic [15:0] LOW_HALF         = 16'hDC00;

    // Windows-1252 mapping of bytes 0x80..0x9F
    localparam logic [15:0] WIN1252_UPPER [0:31] = '{
        16'h20AC, 16'h0081, 16'h201A, 16'h0192, 16'h201E, 16'h2026, 16'h2020, 16'h2021,
        16'h02C6, 16'h2030, 16'h0160, 16'h2039, 16'h0152, 16'h008D, 16'h017D, 16'h008F,
        16'h0090, 16'h2018, 16'h2019, 16'h201C, 16'h201D, 16'h2022, 16'h2013, 16'h2014,
        16'h02DC, 16'h2122, 16'h0161, 16'h203A, 16'h0153, 16'h009D, 16'h017E, 16'h0178
    };

    logic        aclk        = 1'b0;
    logic        aresetn     = 1'b0;
    logic        cfg_wr_en   = 1'b0;
    logic [1:0]  cfg_index   = CFG_SOURCE_IS_UTF8;
    logic [15:0] cfg_wr_data = 16'h0000;
    logic        s_valid     = 1'b0;
    logic        s_ready;
    logic [7:0]  s_in_byte   = 8'h00;
    logic        s_in_last   = 1'b0;
    logic        m_valid;
    logic        m_ready     = 1'b0;
    logic [15:0] m_code_unit;
    logic [1:0]  m_status;
    logic        m_saw_invalid;
    logic        m_is_last;
    logic [15:0] m_unit_count;

    // Register mirror, reset values
    logic        mode_utf8    = 1'b1;
    logic        abort_on_bad = 1'b0;
    logic        end_at_nul   = 1'b0;
    logic [15:0] unit_limit   = 16'h0000;

    // Decoder state mirror
    logic [20:0] pend_cp    = '0;
    logic [1:0]  pend_need  = '0;
    logic [7:0]  pend_lead  = '0;
    logic [15:0] units_made = '0;
    logic        draining   = 1'b0;

    u2u16_result_t step_units[$];
    logic          step_over;
    u2u16_result_t expected_units[$];

    // Idle control and statistics
    bit          idle_off       = 1'b0;
    int          send_gap_pct   = 15;
    int          recv_stall_pct = 15;
    int unsigned quiet_cycles   = 0;
    int          fail_count     = 0;
    int          bytes_sent     = 0;
    int          streams_sent   = 0;
    int          config_writes  = 0;
    int          units_checked  = 0;
    int          replacements   = 0;
    int          pairs_seen     = 0;
    int          aborts_seen    = 0;
    int          capacity_seen  = 0;

    utf8_or_cp1252_to_utf16_unit i_dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_index     (cfg_index),
        .cfg_wr_data   (cfg_wr_data),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_in_byte     (s_in_byte),
        .s_in_last     (s_in_last),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_code_unit   (m_code_unit),
        .m_status      (m_status),
        .m_saw_invalid (m_saw_invalid),
        .m_is_last     (m_is_last),
        .m_unit_count  (m_unit_count)
    );

    // 4 ns clock
    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    // ---------------------------------------------------------------
    // Transcoder prediction
    // ---------------------------------------------------------------
    function automatic void clear_stream();
        pend_cp    = '0;
        pend_need  = '0;
        pend_lead  = '0;
        units_made = '0;
    endfunction

    function automatic void push_result(logic [15:0] unit, logic [1:0] st, logic inv);
        u2u16_result_t r;
        r.code_unit   = unit;
        r.status      = st;
        r.saw_invalid = inv;
        r.is_last     = 1'b0;
        r.unit_count  = units_made;
        step_units.push_back(r);
    endfunction

    function automatic void count_unit(logic [15:0] unit, logic inv);
        if (units_made != 16'hFFFF)
            units_made = units_made + 16'd1;
        push_result(unit, STATUS_OK, inv);
    endfunction

    // Check capacity for all units of the code point, then emit one unit or a pair
    function automatic void emit_code_point(logic [20:0] cp, logic inv);
        logic [20:0] cp_ok;
        logic [20:0] offset;
        int          n_units;
        if (step_over)
            return;
        cp_ok   = (cp > LAST_CODE_POINT) ? {5'h00, REPLACEMENT_UNIT} : cp;
        n_units = (cp_ok >= SUPPLEMENTARY) ? 2 : 1;
        if (unit_limit != 0 && int'(units_made) + n_units > int'(unit_limit)) begin
            push_result(16'h0000, STATUS_CAPACITY, 1'b0);
            step_over = 1'b1;
            return;
        end
        if (n_units == 1) begin
            count_unit(cp_ok[15:0], inv);
        end else begin
            offset = cp_ok - SUPPLEMENTARY;
            count_unit(HIGH_HALF | {6'h00, offset[19:10]}, inv);
            count_unit(LOW_HALF | {6'h00, offset[9:0]}, inv);
        end
    endfunction

    function automatic void report_malformed();
        if (step_over)
            return;
        if (abort_on_bad) begin
            push_result(16'h0000, STATUS_ABORT, 1'b1);
            step_over = 1'b1;
        end else begin
            emit_code_point({5'h00, REPLACEMENT_UNIT}, 1'b1);
        end
    endfunction

    function automatic void decode_lead(logic [7:0] b);
        if (step_over)
            return;
        pend_need = 2'd0;
        if (end_at_nul && b == 8'h00) begin
            emit_code_point(21'h0, 1'b0);
            step_over = 1'b1;
        end else if (b < 8'h80) begin
            emit_code_point({13'h0, b}, 1'b0);
        end else if (b < 8'hC0) begin
            report_malformed();
        end else if (b < 8'hE0) begin
            pend_lead = b;
            pend_cp   = {16'h0, b[4:0]};
            pend_need = 2'd1;
        end else if (b < 8'hF0) begin
            pend_lead = b;
            pend_cp   = {17'h0, b[3:0]};
            pend_need = 2'd2;
        end else if (b < 8'hF8) begin
            pend_lead = b;
            pend_cp   = {18'h0, b[2:0]};
            pend_need = 2'd3;
        end else begin
            report_malformed();
        end
    endfunction

    // Predict the units one accepted byte produces and queue them
    function automatic void transcode_byte(logic [7:0] b, logic last);
        u2u16_result_t tail;
        step_units.delete();
        step_over = 1'b0;
        if (draining) begin
            if (last) begin
                draining = 1'b0;
                clear_stream();
            end
            return;
        end
        if (!mode_utf8) begin
            pend_need = 2'd0;
            if (end_at_nul && b == 8'h00) begin
                emit_code_point(21'h0, 1'b0);
                step_over = 1'b1;
            end else if (b >= 8'h80 && b < 8'hA0) begin
                emit_code_point({5'h00, WIN1252_UPPER[b[4:0]]}, 1'b0);
            end else begin
                emit_code_point({13'h0, b}, 1'b0);
            end
        end else if (pend_need != 2'd0) begin
            if (b[7:6] == 2'b10) begin
                pend_cp   = {pend_cp[14:0], b[5:0]};
                pend_need = pend_need - 2'd1;
                if (pend_need == 2'd0)
                    emit_code_point(pend_cp, 1'b0);
            end else begin
                // bad continuation: replace, then restart on this byte
                pend_need = 2'd0;
                report_malformed();
                decode_lead(b);
            end
        end else begin
            decode_lead(b);
        end
        // sequence left open at end of stream
        if (last && !step_over && pend_need != 2'd0) begin
            pend_need = 2'd0;
            report_malformed();
        end
        if (step_over || last) begin
            if (step_units.size() > 0) begin
                tail = step_units.pop_back();
                tail.is_last = 1'b1;
                step_units.push_back(tail);
            end
            clear_stream();
            draining = !last;
        end
        foreach (step_units[i])
            expected_units.push_back(step_units[i]);
    endfunction

    // ---------------------------------------------------------------
    // Request driving
    // ---------------------------------------------------------------
    task automatic send_byte(logic [7:0] b, logic last);
        int gap;
        @(negedge aclk);
        if (!idle_off && $urandom_range(1, 100) <= send_gap_pct) begin
            s_valid <= 1'b0;
            gap = $urandom_range(1, 14);
            repeat (gap) @(negedge aclk);
        end
        s_valid   <= 1'b1;
        s_in_byte <= b;
        s_in_last <= last;
        do @(posedge aclk); while (!s_ready);
        transcode_byte(b, last);
        bytes_sent++;
    endtask

    // Drop valid and hold until every expected unit is back
    task automatic wait_drained();
        @(negedge aclk);
        s_valid <= 1'b0;
        while (expected_units.size() != 0)
            @(negedge aclk);
        repeat (DRAIN_CYCLES) @(negedge aclk);
    endtask

    task automatic write_reg(logic [1:0] idx, logic [15:0] value);
        @(negedge aclk);
        cfg_wr_en   <= 1'b1;
        cfg_index   <= idx;
        cfg_wr_data <= value;
        @(negedge aclk);
        cfg_wr_en   <= 1'b0;
        case (idx)
            CFG_SOURCE_IS_UTF8:  mode_utf8    = value[0];
            CFG_STOP_ON_INVALID: abort_on_bad = value[0];
            CFG_STOP_AT_NUL:     end_at_nul   = value[0];
            CFG_OUT_CAPACITY:    unit_limit   = value;
            default: ;
        endcase
    endtask

    // Upper data bits of one-bit registers are random and must be ignored
    task automatic set_config(logic utf8, logic abort_bad, logic nul_stop, logic [15:0] cap);
        wait_drained();
        write_reg(CFG_SOURCE_IS_UTF8, {15'($urandom), utf8});
        write_reg(CFG_STOP_ON_INVALID, {15'($urandom), abort_bad});
        write_reg(CFG_STOP_AT_NUL, {15'($urandom), nul_stop});
        write_reg(CFG_OUT_CAPACITY, cap);
        config_writes++;
    endtask

    // Stall the result side in random bursts
    always begin
        @(negedge aclk);
        if (!idle_off && $urandom_range(1, 100) <= recv_stall_pct) begin
            m_ready <= 1'b0;
            repeat ($urandom_range(1, 14)) @(negedge aclk);
        end
        m_ready <= 1'b1;
    end

    // ---------------------------------------------------------------
    // Result checking
    // ---------------------------------------------------------------
    function automatic void check_field(string name, logic [15:0] want, logic [15:0] got);
        if (got !== want) begin
            $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
            fail_count++;
        end
    endfunction

    always @(posedge aclk) begin : check_units
        u2u16_result_t want;
        if (aresetn && m_valid && m_ready) begin
            if (expected_units.size() == 0) begin
                $error("unexpected unit: code_unit 0x%0h status %0d", m_code_unit, m_status);
                fail_count++;
            end else begin
                want = expected_units.pop_front();
                check_field("code_unit", want.code_unit, m_code_unit);
                check_field("status", {14'h0, want.status}, {14'h0, m_status});
                check_field("saw_invalid", {15'h0, want.saw_invalid}, {15'h0, m_saw_invalid});
                check_field("is_last", {15'h0, want.is_last}, {15'h0, m_is_last});
                check_field("unit_count", want.unit_count, m_unit_count);
                units_checked++;
                if (want.saw_invalid && want.status == STATUS_OK)
                    replacements++;
                if (want.status == STATUS_OK && want.code_unit[15:10] == HIGH_HALF[15:10])
                    pairs_seen++;
                if (want.status == STATUS_ABORT)
                    aborts_seen++;
                if (want.status == STATUS_CAPACITY)
                    capacity_seen++;
            end
        end
    end

    // End the run when nothing moves for too long
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles == WATCHDOG_LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    // ---------------------------------------------------------------
    // Tests
    // ---------------------------------------------------------------

    // Reset settings: all UTF-8 lengths, NUL as a plain character, pairs, above range
    task automatic test_utf8_forms();
        send_byte(8'h00, 1'b0);
        send_byte(8'h7F, 1'b0);
        send_byte(8'hC2, 1'b0); send_byte(8'hA9, 1'b0);
        // decoded U+FFFD is a valid character
        send_byte(8'hEF, 1'b0); send_byte(8'hBF, 1'b0); send_byte(8'hBD, 1'b0);
        send_byte(8'hF4, 1'b0); send_byte(8'h8F, 1'b0);
        send_byte(8'hBF, 1'b0); send_byte(8'hBF, 1'b0);
        // above U+10FFFF: replacement that is not flagged invalid
        send_byte(8'hF7, 1'b0); send_byte(8'hBF, 1'b0);
        send_byte(8'hBF, 1'b0); send_byte(8'hBF, 1'b1);
    endtask

    // Stray continuation, bad leads, bad continuation, open sequence at end
    task automatic test_utf8_malformed();
        send_byte(8'h80, 1'b0);
        send_byte(8'hFF, 1'b0);
        send_byte(8'hF8, 1'b0);
        send_byte(8'hC3, 1'b0); send_byte(8'h41, 1'b0);
        send_byte(8'hE2, 1'b0); send_byte(8'h82, 1'b1);
    endtask

    // Abort on a bad continuation, then drain to the end of the stream
    task automatic test_abort_on_invalid();
        set_config(1'b1, 1'b1, 1'b0, 16'h0000);
        send_byte(8'hC3, 1'b0); send_byte(8'h41, 1'b0); send_byte(8'h42, 1'b1);
    endtask

    // Windows-1252 table edges and NUL terminator
    task automatic test_cp1252_and_nul();
        set_config(1'b0, 1'b0, 1'b1, 16'h0000);
        send_byte(8'h80, 1'b0);
        send_byte(8'h9F, 1'b0);
        send_byte(8'hA0, 1'b0);
        send_byte(8'hFF, 1'b0);
        send_byte(8'h7F, 1'b0);
        send_byte(8'h00, 1'b0);
        send_byte(8'h41, 1'b1);
    endtask

    // A pair that does not fit a one-unit capacity
    task automatic test_capacity();
        set_config(1'b1, 1'b0, 1'b0, 16'd1);
        send_byte(8'hF0, 1'b0); send_byte(8'h9F, 1'b0);
        send_byte(8'h98, 1'b0); send_byte(8'h80, 1'b0);
        send_byte(8'h41, 1'b1);
    endtask

    // Mostly well-formed characters with random content, some noise and cut streams
    task automatic send_random_stream();
        logic [7:0] seq[$];
        int         n_chars;
        int         kind;
        int         keep;
        n_chars = $urandom_range(1, 8);
        for (int c = 0; c < n_chars; c++) begin
            kind = $urandom_range(0, 99);
            if (!mode_utf8 || kind >= 92) begin
                seq.push_back(8'($urandom));
            end else if (kind < 25) begin
                seq.push_back(($urandom_range(0, 7) == 0) ? 8'h00 : {1'b0, 7'($urandom)});
            end else if (kind < 45) begin
                seq.push_back({3'b110, 5'($urandom)});
                seq.push_back({2'b10, 6'($urandom)});
            end else if (kind < 65) begin
                seq.push_back({4'b1110, 4'($urandom)});
                repeat (2) seq.push_back({2'b10, 6'($urandom)});
            end else if (kind < 85) begin
                seq.push_back({5'b11110, 3'($urandom)});
                repeat (3) seq.push_back({2'b10, 6'($urandom)});
            end else begin
                // lone lead byte
                seq.push_back({3'b111, 5'($urandom)});
            end
        end
        if ($urandom_range(0, 9) == 0) begin
            keep = $urandom_range(1, seq.size());
            while (seq.size() > keep)
                seq.delete(seq.size() - 1);
        end
        foreach (seq[i])
            send_byte(seq[i], i == seq.size() - 1);
        streams_sent++;
    endtask

    task automatic test_random_streams();
        int phase_start;
        for (int p = 0; p < PHASE_COUNT; p++) begin
            case (p)
                0: set_config(1'b1, 1'b0, 1'b0, 16'hFFFF);
                1: set_config(1'b1, 1'b1, 1'b1, 16'd1);
                2: set_config(1'b0, 1'b0, 1'b1, 16'($urandom_range(2, 8)));
                default: set_config($urandom_range(0, 3) != 0, 1'($urandom), 1'($urandom),
                                    ($urandom_range(0, 2) == 0) ? 16'h0000
                                                                : 16'($urandom_range(1, 24)));
            endcase
            // last phase runs at full rate on both sides
            if (p == PHASE_COUNT - 1) begin
                idle_off = 1'b1;
            end else begin
                send_gap_pct   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(5, 30);
                recv_stall_pct = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(5, 30);
            end
            phase_start = bytes_sent;
            while (bytes_sent - phase_start < PHASE_BYTES)
                send_random_stream();
        end
    endtask

    initial begin
        repeat (10) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        test_utf8_forms();
        test_utf8_malformed();
        test_abort_on_invalid();
        test_cp1252_and_nul();
        test_capacity();
        test_random_streams();
        wait_drained();

        $display("Covered %0d bytes in %0d random streams plus directed cases, %0d settings,",
                 bytes_sent, streams_sent, config_writes);
        $display("%0d units checked: %0d replacements, %0d pairs, %0d aborts, %0d capacity stops",
                 units_checked, replacements, pairs_seen, aborts_seen, capacity_seen);
        if (fail_count == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule

// ===== utf8_or_cp1252_to_utf16_unit.f =====
hdl/u2u16_pkg.sv
hdl/u2u16_decode.sv
hdl/u2u16_res_fifo.sv
hdl/utf8_or_cp1252_to_utf16_unit.sv
tb/sv/tb_utf8_or_cp1252_to_utf16_unit.sv
